// File: hdl/aids_pkg.sv
// shared types, codes and helpers for the array insert/delete/search block
// no dependencies; the other design files and the testbench refer to this package by scoped names
package aids_pkg;

  // request mode codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_LOAD
  } state_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // open a gap at the position and write the key
    logic del;  // close the gap at the position
    logic cmp;  // compare the stored word with the key
  } cell_ctrl_t;

  // number of registered levels of a fan-in-8 OR tree over n flags
  function automatic int tree_levels(input int n);
    int lv;
    begin
      lv = ($clog2(n) + 2) / 3;
      if (lv < 1) lv = 1;
      return lv;
    end
  endfunction

endpackage

// File: hdl/aids_req_if.sv
// request channel: valid/ready handshake with mode, position and data word
// depends on nothing
interface aids_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [6:0]         position;
  logic signed [31:0] data_word;

  modport source (output valid, output mode, output position, output data_word, input ready);
  modport sink   (input valid, input mode, input position, input data_word, output ready);
endinterface

// File: hdl/aids_rsp_if.sv
// response channel: valid/ready handshake with found flag, status and count
// depends on nothing
interface aids_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [1:0] status;
  logic [6:0] entry_count;

  modport source (output valid, output found, output status, output entry_count, input ready);
  modport sink   (input valid, input found, input status, input entry_count, output ready);
endinterface

// File: hdl/aids_cell.sv
// one table slot: holds a word, shifts with its neighbors, compares with the key
// depends on aids_pkg
module aids_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk_i,
  input  aids_pkg::cell_ctrl_t   ctrl_i,
  input  logic                   past_pos_i,
  input  logic                   at_pos_i,
  input  logic                   live_i,
  input  logic [WORD_BITS-1:0]   key_i,
  input  logic [WORD_BITS-1:0]   left_i,
  input  logic [WORD_BITS-1:0]   right_i,
  output logic [WORD_BITS-1:0]   word_o,
  output logic                   match_o
);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 match_q, match_d;

  // next stored word from the broadcast command
  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (past_pos_i) begin
        word_d = left_i;
      end else if (at_pos_i) begin
        word_d = key_i;
      end
    end else if (ctrl_i.del) begin
      if (past_pos_i || at_pos_i) begin
        word_d = right_i;
      end
    end
  end

  // match flag, only for slots holding a live entry
  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp) begin
      match_d = live_i && (word_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    match_q <= match_d;
  end

  assign word_o  = word_q;
  assign match_o = match_q;

endmodule

// File: hdl/aids_or_tree.sv
// registered fan-in-8 OR tree that folds the per-cell match flags
// depends on aids_pkg for the level count
module aids_or_tree #(
  parameter int N = 64
) (
  input  logic         clk_i,
  input  logic [N-1:0] flags_i,
  output logic         any_o
);

  localparam int LEVELS = aids_pkg::tree_levels(N);
  localparam int PAD    = 1 << (3 * LEVELS);
  localparam int GROUPS = PAD / 8;

  logic [PAD-1:0] src   [LEVELS];
  logic [PAD-1:0] lvl_q [LEVELS];

  // level inputs: padded flags, then the previous level
  always_comb begin
    src[0] = PAD'(flags_i);
    for (int k = 1; k < LEVELS; k++) begin
      src[k] = lvl_q[k-1];
    end
  end

  // each level ORs groups of eight into one bit
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < PAD; j++) begin
        if (j < GROUPS) begin
          lvl_q[k][j] <= |src[k][8*j +: 8];
        end else begin
          lvl_q[k][j] <= 1'b0;
        end
      end
    end
  end

  assign any_o = lvl_q[LEVELS-1][0];

endmodule

// File: hdl/array_insert_delete_search.sv
// top level: ordered table built as a row of cells, controller and result register
// depends on aids_pkg, aids_req_if, aids_rsp_if, aids_cell, aids_or_tree
//
// Usage: requests arrive on the req channel (mode, position, data_word), one
// response per request leaves on the rsp channel (found, status, entry_count).
// A transaction happens when valid and ready are both high at a rising edge.
// The table is a row of DEPTH cells; insert and delete shift every cell after
// the position together, search compares all cells at once and folds the
// match flags through a registered OR tree of L = ceil(log8(DEPTH)) levels
// (2 for DEPTH = 64).
// A search response also waits for the match flags to pass the L tree levels.
// One request is worked at a time; a new request is taken as soon as the
// previous response sits in the output register.
// When the receiver stalls, the response is held; the next request is still
// worked and then waits for the output register to empty.
// Reset (rst_ni low) empties the table and drops any pending response; entry
// contents are not cleared, only the entry count.
module array_insert_delete_search #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aids_req_if.sink    req,
  aids_rsp_if.source  rsp
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int LEVELS = aids_pkg::tree_levels(DEPTH);
  localparam int LVL_W  = $clog2(LEVELS + 1);

  aids_pkg::state_e     state_q, state_d;
  aids_pkg::cell_ctrl_t ctrl;

  // latched request
  logic [1:0]           mode_q;
  logic [CMP_W-1:0]     pos_q;
  logic [WORD_BITS-1:0] key_q;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [1:0]           status_q, status_d;
  logic [LVL_W-1:0]     wait_q, wait_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic                 rsp_found_q;
  logic [1:0]           rsp_status_q;
  logic [6:0]           rsp_count_q;

  logic                 req_fire;
  logic                 load_rsp;
  logic                 any_match;
  logic [CMP_W-1:0]     cnt_ext;
  logic                 op_ok;

  logic [WORD_BITS-1:0] cell_word  [DEPTH];
  logic [DEPTH-1:0]     cell_match;

  assign cnt_ext  = CMP_W'(count_q);
  assign req_fire = req.valid && req.ready;

  // bounds check of the latched request
  always_comb begin
    status_d = aids_pkg::STATUS_OK;
    count_d  = count_q;
    case (mode_q)
      aids_pkg::MODE_INSERT: begin
        if (pos_q > cnt_ext) begin
          status_d = aids_pkg::STATUS_RANGE;
        end else if (count_q == CNT_W'(DEPTH)) begin
          status_d = aids_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      aids_pkg::MODE_DELETE: begin
        if (pos_q >= cnt_ext) begin
          status_d = aids_pkg::STATUS_RANGE;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      aids_pkg::MODE_SEARCH: begin
        count_d = count_q;
      end
      aids_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  assign op_ok = (status_d == aids_pkg::STATUS_OK);

  // next state
  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    case (state_q)
      aids_pkg::ST_IDLE: begin
        if (req_fire) state_d = aids_pkg::ST_EXEC;
      end
      aids_pkg::ST_EXEC: begin
        wait_d = '0;
        if (mode_q == aids_pkg::MODE_SEARCH) begin
          state_d = aids_pkg::ST_SEARCH;
        end else begin
          state_d = aids_pkg::ST_LOAD;
        end
      end
      aids_pkg::ST_SEARCH: begin
        wait_d = wait_q + 1'b1;
        if (wait_q == LVL_W'(LEVELS - 1)) state_d = aids_pkg::ST_LOAD;
      end
      aids_pkg::ST_LOAD: begin
        if (!rsp_valid_q || rsp.ready) state_d = aids_pkg::ST_IDLE;
      end
      default: begin
        state_d = aids_pkg::ST_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    ctrl      = '0;
    req.ready = 1'b0;
    load_rsp  = 1'b0;
    case (state_q)
      aids_pkg::ST_IDLE: begin
        req.ready = 1'b1;
      end
      aids_pkg::ST_EXEC: begin
        ctrl.ins = (mode_q == aids_pkg::MODE_INSERT) && op_ok;
        ctrl.del = (mode_q == aids_pkg::MODE_DELETE) && op_ok;
        ctrl.cmp = (mode_q == aids_pkg::MODE_SEARCH);
      end
      aids_pkg::ST_SEARCH: begin
        ctrl = '0;
      end
      aids_pkg::ST_LOAD: begin
        load_rsp = !rsp_valid_q || rsp.ready;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aids_pkg::ST_IDLE;
      count_q     <= '0;
      wait_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      rsp_valid_q <= rsp_valid_d;
      if (state_q == aids_pkg::ST_EXEC) count_q <= count_d;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load_rsp) begin
      rsp_valid_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mode_q <= req.mode;
      pos_q  <= CMP_W'(req.position);
      key_q  <= WORD_BITS'(req.data_word);
    end
    if (state_q == aids_pkg::ST_EXEC) status_q <= status_d;
    if (load_rsp) begin
      rsp_found_q  <= (mode_q == aids_pkg::MODE_SEARCH) && any_match;
      rsp_status_q <= status_q;
      rsp_count_q  <= 7'(count_q);
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = key_q;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    aids_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .past_pos_i (CMP_W'(i) > pos_q),
      .at_pos_i   (CMP_W'(i) == pos_q),
      .live_i     (CMP_W'(i) < cnt_ext),
      .key_i      (key_q),
      .left_i     (left_w),
      .right_i    (right_w),
      .word_o     (cell_word[i]),
      .match_o    (cell_match[i])
    );
  end

  // fold the match flags
  aids_or_tree #(
    .N (DEPTH)
  ) u_or_tree (
    .clk_i   (clk_i),
    .flags_i (cell_match),
    .any_o   (any_match)
  );

  assign rsp.valid       = rsp_valid_q;
  assign rsp.found       = rsp_found_q;
  assign rsp.status      = rsp_status_q;
  assign rsp.entry_count = rsp_count_q;

endmodule

// File: dv/array_insert_delete_search_tb.sv
// self-checking testbench for the array insert/delete/search table
// a shadow copy of the table predicts every response; a scoreboard class checks them in order
// depends on aids_pkg, aids_req_if, aids_rsp_if and array_insert_delete_search
module array_insert_delete_search_tb;

  localparam int DEPTH      = 64;
  localparam int WORD_BITS  = 32;
  localparam int RAND_ITEMS = 1550;

  // one expected or observed response transaction
  typedef struct packed {
    logic       found;
    logic [1:0] status;
    logic [6:0] entry_count;
  } table_rsp_t;

  // shadow table plus the queue of responses still owed by the block
  class table_scoreboard;
    logic [31:0] shadow_words [DEPTH];
    int          shadow_count;
    table_rsp_t  expected_q [$];
    int          errors;

    function new();
      shadow_count = 0;
      errors       = 0;
    endfunction

    // apply an accepted request to the shadow table and queue its response
    function void note_request(logic [1:0] mode, logic [6:0] position, logic [31:0] word);
      table_rsp_t r;
      int         p;
      p             = int'(position);
      r.found       = 1'b0;
      r.status      = aids_pkg::STATUS_OK;
      case (mode)
        aids_pkg::MODE_INSERT: begin
          if (p > shadow_count) begin
            r.status = aids_pkg::STATUS_RANGE;
          end else if (shadow_count >= DEPTH) begin
            r.status = aids_pkg::STATUS_FULL;
          end else begin
            for (int i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
            shadow_words[p] = word;
            shadow_count++;
          end
        end
        aids_pkg::MODE_DELETE: begin
          if (p >= shadow_count) begin
            r.status = aids_pkg::STATUS_RANGE;
          end else begin
            for (int i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
            shadow_count--;
          end
        end
        aids_pkg::MODE_SEARCH: begin
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_words[i] == word) r.found = 1'b1;
          end
        end
        default: begin
          shadow_count = 0;
        end
      endcase
      r.entry_count = shadow_count[6:0];
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one accepted response with the oldest expectation
    task check_response(table_rsp_t got);
      table_rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("response with none outstanding (found %0b status %0d count %0d)",
                         got.found, got.status, got.entry_count));
      end else begin
        want = expected_q.pop_front();
        if (got.found !== want.found)
          report($sformatf("found %0b, expected %0b", got.found, want.found));
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.entry_count !== want.entry_count)
          report($sformatf("entry_count %0d, expected %0d", got.entry_count,
                           want.entry_count));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  aids_req_if req_ch ();
  aids_rsp_if rsp_ch ();

  table_scoreboard sb = new();

  int items_sent    = 0;
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int hold_request  = 0;

  array_insert_delete_search #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch),
    .rsp   (rsp_ch)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // response side: random stalls, long hold-offs on request, check each transaction
  initial begin : rsp_side
    int         hold_left;
    table_rsp_t got;
    hold_left    = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
        got.found       = rsp_ch.found;
        got.status      = rsp_ch.status;
        got.entry_count = rsp_ch.entry_count;
        sb.check_response(got);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // offer one request, with a random idle gap first, and wait for its transaction
  task automatic send_request(logic [1:0] mode, logic [6:0] position, logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.position  <= position;
    req_ch.data_word <= word;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request(mode, position, word);
    items_sent++;
  endtask

  // stop offering and wait until every owed response has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // data word: extremes, copies of stored words, or anything
  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25 && sb.shadow_count > 0)
      return sb.shadow_words[$urandom_range(sb.shadow_count - 1)];
    if (sel < 35) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // insert until full, then a few inserts that must bounce off the full table, then one search
  task automatic fill_burst();
    while (sb.shadow_count < DEPTH)
      send_request(aids_pkg::MODE_INSERT, 7'($urandom_range(sb.shadow_count)), pick_word());
    repeat ($urandom_range(1, 3))
      send_request(aids_pkg::MODE_INSERT, 7'($urandom_range(DEPTH)), $urandom());
    send_request(aids_pkg::MODE_SEARCH, 7'($urandom_range(127)), pick_word());
  endtask

  // delete until empty, then one delete too many
  task automatic drain_burst();
    while (sb.shadow_count > 0)
      send_request(aids_pkg::MODE_DELETE, 7'($urandom_range(sb.shadow_count - 1)),
                   $urandom());
    send_request(aids_pkg::MODE_DELETE, 7'($urandom_range(127)), $urandom());
  endtask

  // mostly legal traffic with random content, some noise
  task automatic mixed_burst(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 38)
        send_request(aids_pkg::MODE_INSERT, 7'($urandom_range(sb.shadow_count)),
                     pick_word());
      else if (sel < 62)
        send_request(aids_pkg::MODE_DELETE,
                     sb.shadow_count > 0 ? 7'($urandom_range(sb.shadow_count - 1)) : 7'd0,
                     $urandom());
      else if (sel < 88)
        send_request(aids_pkg::MODE_SEARCH, 7'($urandom_range(127)), pick_word());
      else if (sel < 90)
        send_request(aids_pkg::MODE_CLEAR, 7'($urandom_range(127)), $urandom());
      else
        send_request(2'($urandom_range(3)), 7'($urandom_range(127)), $urandom());
    end
  endtask

  // stimulus
  initial begin : stim
    int send_pcts  [4];
    int stall_pcts [4];
    int target;
    int sel;
    send_pcts  = '{0, 60, 0, 13};
    stall_pcts = '{0, 0, 60, 13};

    rst_ni           <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= aids_pkg::MODE_SEARCH;
    req_ch.position  <= '0;
    req_ch.data_word <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, range errors, extremes, ignored fields, clear
    send_request(aids_pkg::MODE_SEARCH, 7'd0,   32'h0000_0000);
    send_request(aids_pkg::MODE_DELETE, 7'd0,   32'h0000_0000);
    send_request(aids_pkg::MODE_INSERT, 7'd1,   32'h1234_5678);
    send_request(aids_pkg::MODE_INSERT, 7'd0,   32'h7fff_ffff);
    send_request(aids_pkg::MODE_INSERT, 7'd0,   32'h8000_0000);
    send_request(aids_pkg::MODE_INSERT, 7'd2,   32'h0000_0000);
    send_request(aids_pkg::MODE_INSERT, 7'd1,   32'hffff_ffff);
    send_request(aids_pkg::MODE_SEARCH, 7'd127, 32'h8000_0000);
    send_request(aids_pkg::MODE_SEARCH, 7'd64,  32'h7fff_ffff);
    send_request(aids_pkg::MODE_SEARCH, 7'd0,   32'h0001_2345);
    send_request(aids_pkg::MODE_INSERT, 7'd127, 32'hdead_beef);
    send_request(aids_pkg::MODE_DELETE, 7'd4,   32'h0000_0000);
    send_request(aids_pkg::MODE_DELETE, 7'd127, 32'h0000_0000);
    send_request(aids_pkg::MODE_DELETE, 7'd3,   32'h0000_0000);
    send_request(aids_pkg::MODE_DELETE, 7'd0,   32'hffff_ffff);
    send_request(aids_pkg::MODE_SEARCH, 7'd0,   32'hffff_ffff);
    send_request(aids_pkg::MODE_CLEAR,  7'd127, 32'hffff_ffff);
    send_request(aids_pkg::MODE_SEARCH, 7'd0,   32'h0000_0000);
    send_request(aids_pkg::MODE_DELETE, 7'd0,   32'h0000_0000);
    send_request(aids_pkg::MODE_INSERT, 7'd0,   32'h5555_5555);
    send_request(aids_pkg::MODE_INSERT, 7'd1,   32'haaaa_aaaa);
    send_request(aids_pkg::MODE_SEARCH, 7'd85,  32'haaaa_aaaa);
    send_request(aids_pkg::MODE_CLEAR,  7'd0,   32'h0000_0000);
    wait_drained();

    // random traffic in idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      rsp_stall_pct = stall_pcts[ph];
      target        = items_sent + RAND_ITEMS / 4;
      fill_burst();
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming: input must back up
        hold_request = 300;
        mixed_burst(40);
      end
      while (items_sent < target) begin
        sel = $urandom_range(99);
        if (sel < 20)
          fill_burst();
        else if (sel < 35)
          drain_burst();
        else
          mixed_burst($urandom_range(20, 40));
      end
      wait_drained();
    end

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
